[rtl/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the nearest palette colour search
// Field types, item function codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package nps_pkg;

	// One colour component.
	typedef logic [7:0] color_t;

	// One palette index as seen on the ports.
	typedef logic [7:0] index_t;

	// Function of an input word.
	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 9;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	// Register indexes.
	localparam cfg_index_t REG_PALETTE_COUNT = 8'd0;
	localparam cfg_index_t REG_WEIGHT_RED    = 8'd1;
	localparam cfg_index_t REG_WEIGHT_GREEN  = 8'd2;
	localparam cfg_index_t REG_WEIGHT_BLUE   = 8'd3;

	// Register reset values.
	localparam logic [8:0] COUNT_RESET        = 9'd256;
	localparam color_t     WEIGHT_RED_RESET   = 8'd30;
	localparam color_t     WEIGHT_GREEN_RESET = 8'd59;
	localparam color_t     WEIGHT_BLUE_RESET  = 8'd11;

	// Largest number of entries that the 8-bit index can reach.
	localparam int INDEX_SPAN = 256;

	// Widths of the distance arithmetic.
	localparam int SQ_W   = 16;
	localparam int PROD_W = 24;
	localparam int DIST_W = 26;

endpackage

[rtl/nearest_palette_color_search_top.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top: weighted nearest palette colour search
// Stores RGB palette entries and returns the first nearest entry for a pixel.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall) carries one word per item:
// func selects a palette write or a query, entry_index addresses the write,
// red, green and blue give the entry or the pixel. A write gives no result.
// A query gives one word on the output channel (out_valid, out_stall)
// holding nearest_index.
// Search. A query with N entries to search (N the smallest of palette_count,
// PALETTE_DEPTH and 256) reads the palette memory once a cycle, one entry
// after another, then drains the squaring, weighting and compare stages and
// puts the first nearest index into the output register; only then is the
// next item taken. With N of zero the scan is skipped and the result is
// index 0. in_stall is high for the whole search.
// Stalling. The output register holds its word while out_stall is high; the
// next query may start meanwhile and waits at its end until the register is
// free. Configuration writes (cfg_valid, cfg_ready) are always taken and are
// to be made only while the block is idle.
// Reset. arst_n clears control state and loads the register reset values;
// the palette memory is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  nps_pkg::func_t       func,
	input  nps_pkg::index_t      entry_index,
	input  nps_pkg::color_t      red,
	input  nps_pkg::color_t      green,
	input  nps_pkg::color_t      blue,
	// Output channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output nps_pkg::index_t      nearest_index,
	// Configuration channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  nps_pkg::cfg_index_t  cfg_index,
	input  nps_pkg::cfg_data_t   cfg_data
);

	import nps_pkg::*;

	localparam int AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int LIM_MAX = (PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [8:0]          count_q;
	color_t              weight_red_q;
	color_t              weight_green_q;
	color_t              weight_blue_q;

	logic [8:0]          limit;
	logic [8:0]          limit_q;
	index_t              idx_q;
	logic                last_rd;
	color_t              pix_red_q;
	color_t              pix_green_q;
	color_t              pix_blue_q;

	logic                in_take;
	logic                wr_en;
	logic                rd_en;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic [23:0]         mem [PALETTE_DEPTH];

	logic [23:0]         rd_data_s1;
	logic                v_s1;
	logic                last_s1;
	index_t              idx_s1;

	color_t              dr;
	color_t              dg;
	color_t              db;
	logic [SQ_W-1:0]     sq_r_s2;
	logic [SQ_W-1:0]     sq_g_s2;
	logic [SQ_W-1:0]     sq_b_s2;
	logic                v_s2;
	logic                last_s2;
	index_t              idx_s2;

	logic [PROD_W-1:0]   wr_s3;
	logic [PROD_W-1:0]   wg_s3;
	logic [PROD_W-1:0]   wb_s3;
	logic                v_s3;
	logic                last_s3;
	index_t              idx_s3;

	logic [DIST_W-1:0]   dist_sum;
	logic                take_best;
	logic [DIST_W-1:0]   best_dist_q;
	index_t              best_idx_q;
	logic                have_best_q;

	logic                out_valid_q;
	index_t              nearest_q;

	// Handshake decodes.
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign nearest_index = nearest_q;

	// Number of entries a query searches.
	assign limit = (count_q > 9'(LIM_MAX)) ? 9'(LIM_MAX) : count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= COUNT_RESET;
			weight_red_q   <= WEIGHT_RED_RESET;
			weight_green_q <= WEIGHT_GREEN_RESET;
			weight_blue_q  <= WEIGHT_BLUE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PALETTE_COUNT: count_q        <= cfg_data;
				REG_WEIGHT_RED:    weight_red_q   <= cfg_data[7:0];
				REG_WEIGHT_GREEN:  weight_green_q <= cfg_data[7:0];
				REG_WEIGHT_BLUE:   weight_blue_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Palette memory: one write port, one registered read port.
	assign wr_en   = in_take && (func == FUNC_WRITE) && (32'(entry_index) < PALETTE_DEPTH);
	assign wr_addr = AW'(entry_index);
	assign rd_en   = (state_q == S_SCAN);
	assign rd_addr = AW'(idx_q);
	assign last_rd = ({1'b0, idx_q} == (limit_q - 9'd1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {red, green, blue};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Query pixel and search bounds, captured when a query is taken.
	always_ff @(posedge clk) begin
		if (in_take) begin
			pix_red_q   <= red;
			pix_green_q <= green;
			pix_blue_q  <= blue;
			limit_q     <= limit;
		end
	end

	// Stage one: index and flags travel with the memory read; the valid flags of all stages shift here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		last_s1 <= last_rd;
	end

	// Stage two: absolute differences squared.
	always_comb begin
		dr = (rd_data_s1[23:16] > pix_red_q) ? (rd_data_s1[23:16] - pix_red_q)
		                                      : (pix_red_q - rd_data_s1[23:16]);
		dg = (rd_data_s1[15:8] > pix_green_q) ? (rd_data_s1[15:8] - pix_green_q)
		                                       : (pix_green_q - rd_data_s1[15:8]);
		db = (rd_data_s1[7:0] > pix_blue_q) ? (rd_data_s1[7:0] - pix_blue_q)
		                                     : (pix_blue_q - rd_data_s1[7:0]);
	end

	always_ff @(posedge clk) begin
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
	end

	// Stage three: weighting of each squared difference.
	always_ff @(posedge clk) begin
		wr_s3   <= PROD_W'(weight_red_q) * PROD_W'(sq_r_s2);
		wg_s3   <= PROD_W'(weight_green_q) * PROD_W'(sq_g_s2);
		wb_s3   <= PROD_W'(weight_blue_q) * PROD_W'(sq_b_s2);
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
	end

	// Stage four: distance sum and strict compare against the best so far.
	assign dist_sum  = DIST_W'(wr_s3) + DIST_W'(wg_s3) + DIST_W'(wb_s3);
	assign take_best = v_s3 && (!have_best_q || (dist_sum < best_dist_q));

	always_ff @(posedge clk) begin
		if (take_best) begin
			best_dist_q <= dist_sum;
		end
	end

	// Search sequencer, best index and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			best_idx_q  <= '0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
			nearest_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take_best) begin
				best_idx_q  <= idx_s3;
				have_best_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take && (func == FUNC_QUERY)) begin
						idx_q       <= '0;
						best_idx_q  <= '0;
						have_best_q <= 1'b0;
						state_q     <= (limit == 9'd0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 8'd1;
					if (last_rd) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (v_s3 && last_s3) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						nearest_q   <= best_idx_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the nearest palette colour search
// Writes palette entries and sends pixel queries with random gaps and output
// stalls. Every query is answered by a local copy of the palette and the
// registers, and each returned index is compared in order against it.
// ----------------------------------------------------------------------------
module testbench;
	import nps_pkg::*;

	localparam int PALETTE_DEPTH   = 256;
	localparam int SETTLE_CYCLES   = 8;
	localparam int END_SETTLE      = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int IDLE_PERCENT    = 27;
	localparam int RANDOM_PHASES   = 14;
	localparam int WORDS_PER_PHASE = 80;
	localparam int QUIET_PHASE     = 8;

	typedef struct packed {
		color_t red;
		color_t green;
		color_t blue;
	} rgb_t;

	// Clock, reset and the ports of the block.
	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	func_t      func        = FUNC_WRITE;
	index_t     entry_index = '0;
	color_t     red         = '0;
	color_t     green       = '0;
	color_t     blue        = '0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	index_t     nearest_index;
	logic       cfg_valid   = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index   = '0;
	cfg_data_t  cfg_data    = '0;

	// Local copy of the palette and the registers.
	rgb_t       palette_copy [PALETTE_DEPTH];
	logic [8:0] search_count = COUNT_RESET;
	color_t     red_weight   = WEIGHT_RED_RESET;
	color_t     green_weight = WEIGHT_GREEN_RESET;
	color_t     blue_weight  = WEIGHT_BLUE_RESET;

	// Indices still owed by the block, oldest first.
	index_t expected_index_q [$];

	int   mismatch_count = 0;
	int   quiet_cycles   = 0;
	logic idling         = 1'b1;

	nearest_palette_color_search_top #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.entry_index  (entry_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.nearest_index(nearest_index),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Number of entries a query scans under the current count.
	function automatic int search_span();
		int span;
		span = int'(search_count);
		if (span > PALETTE_DEPTH) span = PALETTE_DEPTH;
		if (span > INDEX_SPAN) span = INDEX_SPAN;
		return span;
	endfunction

	// First entry with the strictly smallest weighted squared distance.
	function automatic index_t nearest_entry(input rgb_t pixel);
		int     span;
		int     dr;
		int     dg;
		int     db;
		int     dist_sum;
		int     best_dist;
		index_t best;
		span = search_span();
		best = '0;
		best_dist = 0;
		for (int i = 0; i < span; i++) begin
			dr = int'(palette_copy[i].red) - int'(pixel.red);
			dg = int'(palette_copy[i].green) - int'(pixel.green);
			db = int'(palette_copy[i].blue) - int'(pixel.blue);
			dist_sum = int'(red_weight) * dr * dr + int'(green_weight) * dg * dg
				+ int'(blue_weight) * db * db;
			if (i == 0 || dist_sum < best_dist) begin
				best_dist = dist_sum;
				best = index_t'(i);
			end
		end
		return best;
	endfunction

	function automatic rgb_t random_colour();
		rgb_t c;
		c.red = 8'($urandom_range(255));
		c.green = 8'($urandom_range(255));
		c.blue = 8'($urandom_range(255));
		return c;
	endfunction

	// A channel value that favours the ends of the range.
	function automatic color_t edge_channel();
		case ($urandom_range(2))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Moves a channel a few steps, clamped to the range.
	function automatic color_t nudge(input color_t c);
		int v;
		v = int'(c) + int'($urandom_range(6)) - 3;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return color_t'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Sends one word and updates the local copy once it is taken.
	task automatic send_word(input func_t f, input index_t idx, input rgb_t c);
		@(negedge clk);
		while (idling && ($urandom_range(99) < IDLE_PERCENT)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_index <= idx;
		red <= c.red;
		green <= c.green;
		blue <= c.blue;
		do @(posedge clk); while (in_stall);
		if (f == FUNC_WRITE) begin
			if (int'(idx) < PALETTE_DEPTH) palette_copy[idx] = c;
		end else begin
			expected_index_q.push_back(nearest_entry(c));
		end
	endtask

	// Holds the input channel idle until every owed index has arrived.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_index_q.size() != 0) @(posedge clk);
	endtask

	task automatic quiesce();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PALETTE_COUNT: search_count = data;
			REG_WEIGHT_RED:    red_weight = data[7:0];
			REG_WEIGHT_GREEN:  green_weight = data[7:0];
			REG_WEIGHT_BLUE:   blue_weight = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input cfg_data_t count, input cfg_data_t wr,
			input cfg_data_t wg, input cfg_data_t wb);
		quiesce();
		write_register(REG_PALETTE_COUNT, count);
		write_register(REG_WEIGHT_RED, wr);
		write_register(REG_WEIGHT_GREEN, wg);
		write_register(REG_WEIGHT_BLUE, wb);
	endtask

	// Extreme colours under the reset weights, including a query right
	// behind the write that changes the answer.
	task automatic test_reset_weights();
		quiesce();
		write_register(REG_PALETTE_COUNT, 9'd4);
		send_word(FUNC_WRITE, 8'd0, rgb_t'(24'h000000));
		send_word(FUNC_WRITE, 8'd1, rgb_t'(24'hFFFFFF));
		send_word(FUNC_WRITE, 8'd2, rgb_t'(24'hFF0000));
		send_word(FUNC_WRITE, 8'd3, rgb_t'(24'h00FF00));
		send_word(FUNC_QUERY, 8'h00, rgb_t'(24'h000000));
		send_word(FUNC_QUERY, 8'hFF, rgb_t'(24'hFFFFFF));
		send_word(FUNC_QUERY, 8'h55, rgb_t'(24'hF01010));
		send_word(FUNC_QUERY, 8'hAA, rgb_t'(24'h7F7F7F));
		send_word(FUNC_WRITE, 8'd3, rgb_t'(24'h7F7F7F));
		send_word(FUNC_QUERY, 8'h00, rgb_t'(24'h808080));
	endtask

	// Equal distances keep the lower index.
	task automatic test_first_of_equals();
		send_word(FUNC_WRITE, 8'd2, rgb_t'(24'hFFFFFF));
		send_word(FUNC_QUERY, 8'h00, rgb_t'(24'hFFFFFF));
		send_word(FUNC_WRITE, 8'd0, rgb_t'(24'hFFFFFF));
		send_word(FUNC_QUERY, 8'h00, rgb_t'(24'hFFFFFF));
	endtask

	// All weights zero make every distance equal; bit 8 of a weight is dropped.
	task automatic test_zero_weights();
		apply_settings(9'd4, 9'd0, 9'd0, 9'd0);
		send_word(FUNC_QUERY, 8'h12, rgb_t'(24'h00FF00));
		apply_settings(9'd4, 9'h100, 9'h100, 9'h1FF);
		send_word(FUNC_QUERY, 8'h34, rgb_t'(24'h0000FF));
	endtask

	// A count of zero scans nothing and reports index zero.
	task automatic test_zero_count();
		apply_settings(9'd0, 9'd30, 9'd59, 9'd11);
		send_word(FUNC_QUERY, 8'h00, rgb_t'(24'hFFFFFF));
		send_word(FUNC_QUERY, 8'hFF, rgb_t'(24'h00FF00));
	endtask

	// Writes to register indexes beyond the list leave the settings alone.
	task automatic test_unknown_register();
		apply_settings(9'd4, 9'd30, 9'd59, 9'd11);
		write_register(cfg_index_t'(4), 9'h1FF);
		write_register(cfg_index_t'(8'hFF), 9'h000);
		send_word(FUNC_QUERY, 8'h00, rgb_t'(24'h00F000));
		send_word(FUNC_QUERY, 8'h00, rgb_t'(24'hF0F0F0));
	endtask

	// Fills the whole palette, with runs of equal entries to force ties.
	task automatic test_fill_palette();
		rgb_t c;
		for (int i = 0; i < PALETTE_DEPTH; i++) begin
			if (i > 0 && $urandom_range(4) == 0) c = palette_copy[i - 1];
			else c = random_colour();
			send_word(FUNC_WRITE, index_t'(i), c);
		end
	endtask

	// One random word: mostly queries, many of them close to a stored entry.
	task automatic random_word();
		int     span;
		index_t idx;
		rgb_t   c;
		span = search_span();
		idx = 8'($urandom_range(255));
		if ($urandom_range(99) < 35) begin
			if (span > 0 && $urandom_range(1) == 0) idx = index_t'($urandom_range(span - 1));
			if ($urandom_range(3) == 0) c = palette_copy[$urandom_range(PALETTE_DEPTH - 1)];
			else c = random_colour();
			send_word(FUNC_WRITE, idx, c);
		end else begin
			case ($urandom_range(3))
				0, 1: c = random_colour();
				2: begin
					if (span > 0) begin
						c = palette_copy[$urandom_range(span - 1)];
						c.red = nudge(c.red);
						c.green = nudge(c.green);
						c.blue = nudge(c.blue);
					end else begin
						c = random_colour();
					end
				end
				default: begin
					c.red = edge_channel();
					c.green = edge_channel();
					c.blue = edge_channel();
				end
			endcase
			send_word(FUNC_QUERY, idx, c);
		end
	endtask

	// Phases of random traffic, each under its own count and weights.
	task automatic test_random_traffic();
		cfg_data_t count;
		cfg_data_t wr;
		cfg_data_t wg;
		cfg_data_t wb;
		int        pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick = $urandom_range(99);
			if (pick < 60) count = cfg_data_t'($urandom_range(16, 1));
			else if (pick < 85) count = cfg_data_t'($urandom_range(64, 17));
			else if (pick < 93) count = cfg_data_t'($urandom_range(255, 65));
			else count = cfg_data_t'($urandom_range(511, 257));
			case (phase)
				0: count = 9'd1;
				1: count = 9'd256;
				2: count = 9'd511;
				3: count = 9'd0;
				4: count = 9'd2;
				default: ;
			endcase
			wr = ($urandom_range(9) == 0) ? 9'd0 : cfg_data_t'($urandom_range(511));
			wg = ($urandom_range(9) == 0) ? 9'd0 : cfg_data_t'($urandom_range(511));
			wb = ($urandom_range(9) == 0) ? 9'd0 : cfg_data_t'($urandom_range(511));
			case (phase)
				5: begin wr = 9'd0;   wg = 9'd0;   wb = 9'd0;   end
				6: begin wr = 9'h1FF; wg = 9'h1FF; wb = 9'h1FF; end
				7: begin wr = 9'h0FF; wg = 9'h000; wb = 9'h0FF; end
				default: ;
			endcase
			apply_settings(count, wr, wg, wb);
			idling = (phase != QUIET_PHASE);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				random_word();
				// Now and then the sender holds off until the block has caught up.
				if ($urandom_range(49) == 0) wait_for_results();
			end
		end
		idling = 1'b1;
	endtask

	// The receiver stalls at random while idling is enabled.
	always @(negedge clk) begin
		out_stall <= idling && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Each word taken from the output is matched against the oldest expectation.
	always @(posedge clk) begin
		index_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_index_q.size() == 0) begin
				report_mismatch($sformatf("index %0d with no query outstanding",
					nearest_index));
			end else begin
				want = expected_index_q.pop_front();
				if (nearest_index !== want)
					report_mismatch($sformatf("nearest_index %0d, expected %0d",
						nearest_index, want));
			end
		end
	end

	// Counts cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("Watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_weights();
		test_first_of_equals();
		test_zero_weights();
		test_zero_count();
		test_unknown_register();
		test_fill_palette();
		test_random_traffic();
		wait_for_results();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatch_count == 0 && expected_index_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
